>>> rtl/morse_code_keyer_top_macros.svh
// Assertion macros shared by the keyer RTL files.
`ifndef MORSE_CODE_KEYER_TOP_MACROS_SVH
`define MORSE_CODE_KEYER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Checked property on clk_i, switched off while rst_ni is low.
`define MCK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked property on clk_i that must also hold during reset.
`define MCK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define MCK_ASSERT(lbl, prop, msg)
`define MCK_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/mck_pkg.sv
// Types, constants and the letter table of the Morse code keyer.
package mck_pkg;

  // Width of the phase timer and of the configured durations.
  localparam int unsigned TimerWidth = 16;
  localparam int unsigned DurWidth   = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned NumLetters = 26;

  typedef enum logic [1:0] {
    ModeTick        = 2'd0,
    ModeLetter      = 2'd1,
    ModeLetterSpace = 2'd2,
    ModeWordSpace   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhMark  = 2'd1,
    PhGap   = 2'd2,
    PhPause = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegDot       = 3'd0,
    RegDash      = 3'd1,
    RegSymbolGap = 3'd2,
    RegLetterGap = 3'd3,
    RegWordGap   = 3'd4
  } cfg_idx_e;

  // Durations in ticks, as held by the configuration registers.
  typedef struct packed {
    logic [DurWidth-1:0] dot_ticks;
    logic [DurWidth-1:0] dash_ticks;
    logic [DurWidth-1:0] symbol_gap_ticks;
    logic [DurWidth-1:0] letter_gap_ticks;
    logic [DurWidth-1:0] word_gap_ticks;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic led_on;
    logic busy_res;
    logic accepted;
  } res_t;

  // Symbol pattern of each letter: bit i is symbol i, 1 is a dash.
  localparam logic [3:0] SymCode [NumLetters] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  // Number of symbols of each letter.
  localparam logic [2:0] SymLen [NumLetters] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  // Largest count the phase timer can hold.
  localparam logic [32:0] TimerMax = (33'd1 << TimerWidth) - 33'd1;

  // Saturate a configured duration to the range of the phase timer.
  function automatic logic [TimerWidth-1:0] clamp_timer(input logic [DurWidth-1:0] v);
    logic [32:0] v_ext;
    v_ext = 33'(v);
    if (v_ext > TimerMax) begin
      return '1;
    end
    return TimerWidth'(v_ext);
  endfunction

endpackage

>>> rtl/mck_if.sv
// Valid/ready channel interfaces of the keyer: input items, results and register writes.
interface mck_item_if;
  import mck_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [4:0] letter;
  modport source (output valid, output mode, output letter, input ready);
  modport sink (input valid, input mode, input letter, output ready);
endinterface

interface mck_res_if;
  logic valid;
  logic ready;
  logic led_on;
  logic busy_res;
  logic accepted;
  modport source (output valid, output led_on, output busy_res, output accepted, input ready);
  modport sink (input valid, input led_on, input busy_res, input accepted, output ready);
endinterface

interface mck_cfg_if;
  import mck_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [DurWidth-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/mck_cfg_regs.sv
// Configuration register file holding the five keying durations.
module mck_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  mck_cfg_if.sink       cfg_i,
  output mck_pkg::cfg_t cfg_o
);
  import mck_pkg::*;

  cfg_t cfg_q;

  // Writes are always taken; an unknown index is dropped.
  assign cfg_i.ready = 1'b1;

  // Register update on each write beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot_ticks        <= DurWidth'(20);
      cfg_q.dash_ticks       <= DurWidth'(60);
      cfg_q.symbol_gap_ticks <= DurWidth'(100);
      cfg_q.letter_gap_ticks <= DurWidth'(200);
      cfg_q.word_gap_ticks   <= DurWidth'(400);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegDot:       cfg_q.dot_ticks        <= cfg_i.data;
        RegDash:      cfg_q.dash_ticks       <= cfg_i.data;
        RegSymbolGap: cfg_q.symbol_gap_ticks <= cfg_i.data;
        RegLetterGap: cfg_q.letter_gap_ticks <= cfg_i.data;
        RegWordGap:   cfg_q.word_gap_ticks   <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/mck_core.sv
// Keyer state machine: phase, symbol pattern and phase timer, one item per step.
`include "morse_code_keyer_top_macros.svh"

module mck_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [1:0]    mode_i,
  input  logic [4:0]    letter_i,
  input  mck_pkg::cfg_t cfg_i,
  output mck_pkg::res_t res_o
);
  import mck_pkg::*;

  phase_e                phase_q, phase_d;
  logic [3:0]            pattern_q, pattern_d;
  logic [2:0]            symbols_q, symbols_d;
  logic [TimerWidth-1:0] ticks_q, ticks_d;

  logic       is_tick;
  logic       timer_done;
  logic       letter_ok;
  logic [3:0] load_code;
  logic [2:0] load_len;
  logic       accepted;

  // Decode of the current item.
  assign is_tick    = (mode_i == ModeTick);
  assign timer_done = (ticks_q <= TimerWidth'(1));
  assign letter_ok  = (letter_i < 5'(NumLetters));
  assign load_code  = letter_ok ? SymCode[letter_i] : 4'd0;
  assign load_len   = letter_ok ? SymLen[letter_i] : 3'd0;
  assign accepted   = !is_tick && (phase_q == PhIdle) &&
                      ((mode_i != ModeLetter) || letter_ok);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      if (is_tick) begin
        if ((phase_q != PhIdle) && timer_done) begin
          unique case (phase_q)
            PhMark:  phase_d = PhGap;
            PhGap:   phase_d = (symbols_q != 3'd0) ? PhMark : PhIdle;
            default: phase_d = PhIdle;
          endcase
        end
      end else if (accepted) begin
        phase_d = (mode_i == ModeLetter) ? PhMark : PhPause;
      end
    end
  end

  // Pattern, symbol count and timer that go with the phase change.
  always_comb begin
    pattern_d = pattern_q;
    symbols_d = symbols_q;
    ticks_d   = ticks_q;
    if (step_i) begin
      if (is_tick) begin
        if ((phase_q != PhIdle) && timer_done) begin
          if (phase_q == PhMark) begin
            ticks_d = clamp_timer(cfg_i.symbol_gap_ticks);
          end else if ((phase_q == PhGap) && (symbols_q != 3'd0)) begin
            // Start the next symbol of the letter.
            pattern_d = {1'b0, pattern_q[3:1]};
            symbols_d = symbols_q - 3'd1;
            ticks_d   = clamp_timer(pattern_q[0] ? cfg_i.dash_ticks : cfg_i.dot_ticks);
          end else begin
            pattern_d = '0;
            symbols_d = '0;
            ticks_d   = '0;
          end
        end else if (phase_q != PhIdle) begin
          ticks_d = ticks_q - TimerWidth'(1);
        end
      end else if (accepted) begin
        if (mode_i == ModeLetter) begin
          // Load the letter and light the first symbol at once.
          pattern_d = {1'b0, load_code[3:1]};
          symbols_d = load_len - 3'd1;
          ticks_d   = clamp_timer(load_code[0] ? cfg_i.dash_ticks : cfg_i.dot_ticks);
        end else begin
          ticks_d = clamp_timer((mode_i == ModeLetterSpace) ? cfg_i.letter_gap_ticks
                                                            : cfg_i.word_gap_ticks);
        end
      end
    end
  end

  // Result fields follow the state after this item.
  always_comb begin
    res_o.led_on   = (phase_d == PhMark);
    res_o.busy_res = (phase_d != PhIdle);
    res_o.accepted = step_i && accepted;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      pattern_q <= '0;
      symbols_q <= '0;
      ticks_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      pattern_q <= pattern_d;
      symbols_q <= symbols_d;
      ticks_q   <= ticks_d;
    end
  end

  `MCK_ASSERT_ALWAYS(a_idle_clear, (phase_q == PhIdle) |-> ((pattern_q == 4'd0) && (symbols_q == 3'd0)), "idle keyer holds a leftover pattern")
  `MCK_ASSERT(a_tick_counts_down, (step_i && is_tick && (phase_q != PhIdle) && !timer_done) |=> (ticks_q == $past(ticks_q) - TimerWidth'(1)), "phase timer did not count down")
  `MCK_ASSERT(a_accept_only_idle, (step_i && res_o.accepted) |-> (phase_q == PhIdle), "command taken while busy")

endmodule

>>> rtl/morse_code_keyer_top.sv
// Morse code keyer top level: input register, keyer core and result register.
// The keyer takes one item per clock cycle while the result channel is not stalled
// and returns one result per item through the input and result registers. A tick
// item advances the current mark, gap or pause by one tick; a send-letter item
// plays the letter's dots and dashes, each followed by a dark symbol gap;
// letter-space and word-space items start a dark pause. Commands that arrive while
// a letter or pause is still playing are refused with accepted low. The keyer
// state update sits between the input and result registers; the input register
// can take a new item while a result still waits, but the item steps on only once
// the result register is free or drained. Durations are to be written through the
// configuration channel while the keyer is idle; the block does not enforce this.
`include "morse_code_keyer_top_macros.svh"

module morse_code_keyer_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  mck_item_if.sink in_i,
  mck_res_if.source out_o,
  mck_cfg_if.sink  cfg_i
);
  import mck_pkg::*;

  logic       in_valid_q;
  logic [1:0] in_mode_q;
  logic [4:0] in_letter_q;
  logic       out_valid_q;
  res_t       out_res_q;
  res_t       res_d;
  cfg_t       cfg;
  logic       step;

  // An item moves on when the result register is free or being drained.
  assign step       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_mode_q   <= in_i.mode;
      in_letter_q <= in_i.letter;
    end
  end

  mck_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  mck_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .mode_i   (in_mode_q),
    .letter_i (in_letter_q),
    .cfg_i    (cfg),
    .res_o    (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= res_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.led_on   = out_res_q.led_on;
  assign out_o.busy_res = out_res_q.busy_res;
  assign out_o.accepted = out_res_q.accepted;

  `MCK_ASSERT(a_ready_when_empty, (!out_valid_q) |-> in_i.ready, "input stalled with an empty result register")
  `MCK_ASSERT(a_step_fills_out, step |=> out_valid_q, "result beat lost after a step")
  `MCK_ASSERT(a_out_held, (out_valid_q && !out_o.ready) |=> out_valid_q, "stalled result dropped")

endmodule

>>> bench/tb.sv
// Testbench of the Morse code keyer: a directed table, a full-scale run, then random beats checked by a predictor.
`timescale 1ns / 1ps

module tb;
  import mck_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned IdlePct    = 38;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned NumPhases  = 6;

  // Register indexes that the keyer ignores.
  localparam logic [CfgIdxW-1:0] RegFirstUnused = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLastUnused  = 3'd7;

  localparam logic [DurWidth-1:0] DurMax = '1;

  // Letters named in the directed table.
  localparam logic [4:0] LtrA      = 5'd0;
  localparam logic [4:0] LtrE      = 5'd4;
  localparam logic [4:0] LtrJ      = 5'd9;
  localparam logic [4:0] LtrQ      = 5'd16;
  localparam logic [4:0] LtrT      = 5'd19;
  localparam logic [4:0] LtrY      = 5'd24;
  localparam logic [4:0] LtrZ      = 5'd25;
  localparam logic [4:0] LtrPastZ  = 5'(NumLetters);
  localparam logic [4:0] LtrTop    = 5'd31;

  // Short durations for the second half of the table; the zero symbol gap acts as one tick.
  localparam cfg_t ShortDur = '{16'd1, 16'd2, 16'd0, 16'd2, 16'd3};

  // One table row: reps of zero means ticks until the keyer is idle again.
  typedef struct packed {
    mode_e      mode;
    logic [4:0] letter;
    logic [7:0] reps;
    logic       reconf;
    logic       typed;
    res_t       res;
  } dir_row_t;

  localparam int unsigned NumRows = 25;
  localparam dir_row_t DirRows [NumRows] = '{
    // Reset durations: tick while idle, bad letters, a letter, refused commands, a word space.
    '{ModeTick,        LtrA,     8'd1,  1'b0, 1'b1, 3'b000},
    '{ModeLetter,      LtrTop,   8'd1,  1'b0, 1'b1, 3'b000},
    '{ModeLetter,      LtrPastZ, 8'd1,  1'b0, 1'b1, 3'b000},
    '{ModeLetter,      LtrE,     8'd1,  1'b0, 1'b1, 3'b111},
    '{ModeLetter,      LtrA,     8'd1,  1'b0, 1'b1, 3'b110},
    '{ModeLetterSpace, LtrA,     8'd1,  1'b0, 1'b1, 3'b110},
    '{ModeTick,        LtrA,     8'd0,  1'b0, 1'b0, 3'b000},
    '{ModeWordSpace,   LtrTop,   8'd1,  1'b0, 1'b1, 3'b011},
    '{ModeWordSpace,   LtrA,     8'd1,  1'b0, 1'b1, 3'b010},
    '{ModeTick,        LtrA,     8'd0,  1'b0, 1'b0, 3'b000},
    // Short durations: Z as dash dash dot dot, pauses, and the remaining shapes.
    '{ModeLetter,      LtrZ,     8'd1,  1'b1, 1'b1, 3'b111},
    '{ModeWordSpace,   LtrA,     8'd1,  1'b0, 1'b1, 3'b110},
    '{ModeTick,        LtrTop,   8'd12, 1'b0, 1'b0, 3'b000},
    '{ModeLetterSpace, LtrA,     8'd1,  1'b0, 1'b1, 3'b011},
    '{ModeLetter,      LtrQ,     8'd1,  1'b0, 1'b1, 3'b010},
    '{ModeTick,        LtrA,     8'd3,  1'b0, 1'b0, 3'b000},
    '{ModeWordSpace,   LtrA,     8'd1,  1'b0, 1'b1, 3'b011},
    '{ModeTick,        LtrA,     8'd0,  1'b0, 1'b0, 3'b000},
    '{ModeLetter,      LtrT,     8'd1,  1'b0, 1'b1, 3'b111},
    '{ModeTick,        LtrA,     8'd0,  1'b0, 1'b0, 3'b000},
    '{ModeLetter,      LtrJ,     8'd1,  1'b0, 1'b1, 3'b111},
    '{ModeTick,        LtrA,     8'd0,  1'b0, 1'b0, 3'b000},
    '{ModeLetter,      LtrY,     8'd1,  1'b0, 1'b1, 3'b111},
    '{ModeTick,        LtrA,     8'd0,  1'b0, 1'b0, 3'b000},
    '{ModeLetter,      LtrQ,     8'd1,  1'b0, 1'b0, 3'b000}
  };

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int   mismatch_cnt;
  int unsigned quiet_cycles;

  mck_item_if item_if ();
  mck_res_if  res_if ();
  mck_cfg_if  cfg_if ();

  morse_code_keyer_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Predicted keyer state and durations.
  phase_e                keyer_phase;
  logic [3:0]            keyer_pattern;
  logic [2:0]            keyer_syms_left;
  logic [TimerWidth-1:0] keyer_ticks;
  cfg_t                  dur;

  // Status beats still owed by the keyer, oldest first.
  res_t pending_status[$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Dots and dashes of each letter in plain notation.
  function automatic string morse_of(input logic [4:0] l);
    case (l)
      5'd0:  return ".-";
      5'd1:  return "-...";
      5'd2:  return "-.-.";
      5'd3:  return "-..";
      5'd4:  return ".";
      5'd5:  return "..-.";
      5'd6:  return "--.";
      5'd7:  return "....";
      5'd8:  return "..";
      5'd9:  return ".---";
      5'd10: return "-.-";
      5'd11: return ".-..";
      5'd12: return "--";
      5'd13: return "-.";
      5'd14: return "---";
      5'd15: return ".--.";
      5'd16: return "--.-";
      5'd17: return ".-.";
      5'd18: return "...";
      5'd19: return "-";
      5'd20: return "..-";
      5'd21: return "...-";
      5'd22: return ".--";
      5'd23: return "-..-";
      5'd24: return "-.--";
      default: return "--..";
    endcase
  endfunction

  // A duration longer than the phase timer can count saturates.
  function automatic logic [TimerWidth-1:0] timer_load(input logic [DurWidth-1:0] d);
    return ((d >> TimerWidth) != '0) ? '1 : TimerWidth'(d);
  endfunction

  // Start the lit mark of the next symbol.
  function automatic void next_symbol();
    logic is_dash;
    is_dash         = keyer_pattern[0];
    keyer_pattern   = keyer_pattern >> 1;
    keyer_syms_left = keyer_syms_left - 3'd1;
    keyer_phase     = PhMark;
    keyer_ticks     = timer_load(is_dash ? dur.dash_ticks : dur.dot_ticks);
  endfunction

  // Apply one input beat to the predicted state and return the status it yields.
  function automatic res_t advance_keyer(input mode_e m, input logic [4:0] l);
    res_t  r;
    string code;
    r.accepted = 1'b0;
    if (m == ModeTick) begin
      if (keyer_phase != PhIdle) begin
        if (keyer_ticks <= 1) begin
          keyer_ticks = '0;
          if (keyer_phase == PhMark) begin
            keyer_phase = PhGap;
            keyer_ticks = timer_load(dur.symbol_gap_ticks);
          end else if (keyer_phase == PhGap && keyer_syms_left != '0) begin
            next_symbol();
          end else begin
            keyer_phase     = PhIdle;
            keyer_pattern   = '0;
            keyer_syms_left = '0;
          end
        end else begin
          keyer_ticks = keyer_ticks - 1'b1;
        end
      end
    end else if (keyer_phase == PhIdle) begin
      if (m == ModeLetter) begin
        if (l < NumLetters) begin
          code          = morse_of(l);
          keyer_pattern = '0;
          for (int i = 0; i < code.len(); i++) begin
            keyer_pattern[i] = (code[i] == "-");
          end
          keyer_syms_left = 3'(code.len());
          next_symbol();
          r.accepted = 1'b1;
        end
      end else begin
        keyer_phase = PhPause;
        keyer_ticks = timer_load(m == ModeLetterSpace ? dur.letter_gap_ticks
                                                      : dur.word_gap_ticks);
        r.accepted  = 1'b1;
      end
    end
    r.led_on   = (keyer_phase == PhMark);
    r.busy_res = (keyer_phase != PhIdle);
    return r;
  endfunction

  // Offer one item beat, with random idle cycles ahead of it, and log what it should yield.
  task automatic send_item(input mode_e m, input logic [4:0] l, input logic typed,
                           input res_t typed_res);
    res_t r;
    while (!steady && $urandom_range(99) < IdlePct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid  <= 1'b1;
    item_if.mode   <= m;
    item_if.letter <= l;
    do @(posedge clk_i); while (!item_if.ready);
    r = advance_keyer(m, l);
    pending_status.push_back(typed ? typed_res : r);
  endtask

  // Tick until the current letter or pause has played out.
  task automatic run_out();
    while (keyer_phase != PhIdle) begin
      send_item(ModeTick, 5'($urandom_range(31)), 1'b0, '0);
    end
  endtask

  // Hold the item channel until every owed status beat has come back.
  task automatic settle();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_status.size() != 0);
  endtask

  // Write one register; valid stays high for a following write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DurWidth-1:0] d);
    while (!steady && $urandom_range(99) < IdlePct) begin
      cfg_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      RegDot:       dur.dot_ticks        = d;
      RegDash:      dur.dash_ticks       = d;
      RegSymbolGap: dur.symbol_gap_ticks = d;
      RegLetterGap: dur.letter_gap_ticks = d;
      RegWordGap:   dur.word_gap_ticks   = d;
      default: ;
    endcase
  endtask

  // Write all five durations and one ignored index while nothing is in flight.
  task automatic load_durations(input cfg_t d);
    settle();
    write_reg(RegDot, d.dot_ticks);
    write_reg(RegDash, d.dash_ticks);
    write_reg(RegSymbolGap, d.symbol_gap_ticks);
    write_reg(CfgIdxW'($urandom_range(RegLastUnused, RegFirstUnused)),
              DurWidth'($urandom_range(DurMax)));
    write_reg(RegLetterGap, d.letter_gap_ticks);
    write_reg(RegWordGap, d.word_gap_ticks);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly short durations so letters finish quickly, sometimes zero or longer ones.
  function automatic logic [DurWidth-1:0] random_dur();
    case ($urandom_range(7))
      0:       return '0;
      1:       return DurWidth'($urandom_range(40, 10));
      default: return DurWidth'($urandom_range(6, 1));
    endcase
  endfunction

  // Commands mostly when idle, ticks otherwise, with a share of refused commands.
  task automatic random_item();
    mode_e       m;
    logic [4:0]  l;
    int unsigned roll;
    l    = 5'($urandom_range(31));
    m    = ModeTick;
    roll = $urandom_range(99);
    if ((keyer_phase == PhIdle && roll < 70) || roll < 12) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        m = ModeLetter;
        if ($urandom_range(19) != 0) l = 5'($urandom_range(NumLetters - 1));
      end else if (roll < 80) begin
        m = ModeLetterSpace;
      end else begin
        m = ModeWordSpace;
      end
    end
    send_item(m, l, 1'b0, '0);
  endtask

  // Result side: random stalls except during steady stretches.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Compare every status beat with the oldest owed one.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_status.size() == 0) begin
        $error("status beat with no item waiting");
        mismatch_cnt++;
      end else begin
        want = pending_status.pop_front();
        check_field("led_on", want.led_on, res_if.led_on);
        check_field("busy_res", want.busy_res, res_if.busy_res);
        check_field("accepted", want.accepted, res_if.accepted);
      end
    end
  end

  // Watchdog: end the run after too many cycles without any beat.
  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus: reset, directed table, full-scale registers without idling, random phases.
  initial begin
    cfg_t d;
    item_if.valid   = 1'b0;
    item_if.mode    = ModeTick;
    item_if.letter  = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = RegDot;
    cfg_if.data     = '0;
    steady          = 1'b0;
    mismatch_cnt    = 0;
    quiet_cycles    = 0;
    keyer_phase     = PhIdle;
    keyer_pattern   = '0;
    keyer_syms_left = '0;
    keyer_ticks     = '0;
    dur             = '{16'd20, 16'd60, 16'd100, 16'd200, 16'd400};
    rst_ni          = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    for (int i = 0; i < NumRows; i++) begin
      if (DirRows[i].reconf) begin
        run_out();
        load_durations(ShortDur);
      end
      if (DirRows[i].reps == 0) begin
        run_out();
      end else begin
        repeat (DirRows[i].reps) begin
          send_item(DirRows[i].mode, DirRows[i].letter, DirRows[i].typed, DirRows[i].res);
        end
      end
    end

    // Full-scale values on the registers that E does not play, run without any idling.
    run_out();
    steady <= 1'b1;
    load_durations('{16'd3, DurMax, 16'd2, DurMax, DurMax});
    send_item(ModeLetter, LtrE, 1'b1, 3'b111);
    run_out();

    // Random phases, each under a fresh set of durations.
    for (int p = 0; p < NumPhases; p++) begin
      run_out();
      steady <= (p == 2);
      if (p == 0) begin
        d = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
      end else begin
        d = '{random_dur(), random_dur(), random_dur(), random_dur(), random_dur()};
      end
      load_durations(d);
      for (int k = 0; k < PhaseItems; k++) begin
        if ($urandom_range(199) == 0) settle();
        random_item();
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> morse_code_keyer_top.f
+incdir+rtl
rtl/mck_pkg.sv
rtl/mck_if.sv
rtl/mck_cfg_regs.sv
rtl/mck_core.sv
rtl/morse_code_keyer_top.sv
bench/tb.sv
